@@ rtl/core/mono_bitmap_row_unpad_pack_core_defines.svh @@
// Assertion macros shared by the mono bitmap row unpack/pack core.
`ifndef MONO_BITMAP_ROW_UNPAD_PACK_CORE_DEFINES_SVH
`define MONO_BITMAP_ROW_UNPAD_PACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBRUP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBRUP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mbrup_pkg.sv @@
// Shared types for the mono bitmap row unpack/pack core.
`default_nettype none

package mbrup_pkg;

    typedef struct packed {
        logic [7:0] box_width;
        logic [7:0] box_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } result_t;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

    localparam int unsigned REG_BOX_WIDTH  = 0;
    localparam int unsigned REG_BOX_HEIGHT = 1;

    localparam logic [7:0] BOX_WIDTH_RESET  = 8'd8;
    localparam logic [7:0] BOX_HEIGHT_RESET = 8'd0;

endpackage

`default_nettype wire

@@ rtl/core/mbrup_bit_packer.sv @@
// Row unpad and bit pack stage: counters, bit accumulator and result pair.
`default_nettype none

`include "mono_bitmap_row_unpad_pack_core_defines.svh"

module mbrup_bit_packer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_beat,
    input  wire logic [7:0]      src_byte,
    input  wire mbrup_pkg::cfg_t cfg,
    output mbrup_pkg::push_t     push
);

    logic [7:0] bit_accum_reg, bit_accum_next;
    logic [2:0] bit_fill_reg, bit_fill_next;
    logic [4:0] col_byte_count_reg, col_byte_count_next;
    logic [7:0] row_count_reg, row_count_next;

    logic [7:0]  w_eff;
    logic [7:0]  w_m1;
    logic        end_row;
    logic [3:0]  nbits;
    logic [3:0]  total;
    logic [15:0] combined;
    logic        full;
    logic [7:0]  full_byte;
    logic [2:0]  fill_new;
    logic [7:0]  accum_new;
    logic [7:0]  flush_byte;
    logic        glyph_end;
    logic        flush;
    logic        active;

    always_comb begin
        w_eff     = (cfg.box_width == 8'd0) ? 8'd1 : cfg.box_width;
        w_m1      = w_eff - 8'd1;
        end_row   = (col_byte_count_reg >= w_m1[7:3]);
        nbits     = end_row ? ({1'b0, w_m1[2:0]} + 4'd1) : 4'd8;
        total     = {1'b0, bit_fill_reg} + nbits;
        combined  = ({8'd0, bit_accum_reg} << nbits)
                  | {8'd0, (src_byte >> (4'd8 - nbits))};
        full      = total[3];
        full_byte = 8'(combined >> total[2:0]);
        fill_new  = total[2:0];
        accum_new = combined[7:0] & ((8'd1 << fill_new) - 8'd1);
        flush_byte = accum_new << (3'd0 - fill_new);
        glyph_end = end_row && (row_count_reg >= (cfg.box_height - 8'd1));
        flush     = glyph_end && (fill_new != 3'd0);
        active    = in_beat && (cfg.box_height != 8'd0);
    end

    always_comb begin
        push.valid0           = active && (full || flush);
        push.valid1           = active && full && flush;
        push.res0.packed_byte = full ? full_byte : flush_byte;
        push.res0.last_byte   = full ? (glyph_end && !flush) : 1'b1;
        push.res1.packed_byte = flush_byte;
        push.res1.last_byte   = 1'b1;
    end

    always_comb begin
        bit_accum_next      = bit_accum_reg;
        bit_fill_next       = bit_fill_reg;
        col_byte_count_next = col_byte_count_reg;
        row_count_next      = row_count_reg;
        if (active) begin
            if (glyph_end) begin
                bit_accum_next      = 8'd0;
                bit_fill_next       = 3'd0;
                col_byte_count_next = 5'd0;
                row_count_next      = 8'd0;
            end else begin
                bit_accum_next = accum_new;
                bit_fill_next  = fill_new;
                if (end_row) begin
                    col_byte_count_next = 5'd0;
                    row_count_next      = row_count_reg + 8'd1;
                end else begin
                    col_byte_count_next = col_byte_count_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_accum_reg      <= 8'd0;
            bit_fill_reg       <= 3'd0;
            col_byte_count_reg <= 5'd0;
            row_count_reg      <= 8'd0;
        end else begin
            bit_accum_reg      <= bit_accum_next;
            bit_fill_reg       <= bit_fill_next;
            col_byte_count_reg <= col_byte_count_next;
            row_count_reg      <= row_count_next;
        end
    end

    `MBRUP_ASSERT_NEXT(a_glyph_end_clears, aclk, aresetn, active && glyph_end, (bit_fill_reg == 3'd0) && (row_count_reg == 8'd0) && (col_byte_count_reg == 5'd0), "state not cleared after glyph end")
    `MBRUP_ASSERT_NOW(a_accum_clean, aclk, aresetn, 1'b1, (bit_accum_reg >> bit_fill_reg) == 8'd0, "stale bits above fill level")
    `MBRUP_ASSERT_NOW(a_pair_last, aclk, aresetn, push.valid1, push.res1.last_byte && !push.res0.last_byte, "last flag on wrong beat")

endmodule

`default_nettype wire

@@ rtl/core/mbrup_out_queue.sv @@
// Result queue: takes up to two results a cycle, hands out one beat a cycle while out_ready is high.
`default_nettype none

`include "mono_bitmap_row_unpad_pack_core_defines.svh"

module mbrup_out_queue #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mbrup_pkg::push_t   push,
    output logic                    space_ok,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mbrup_pkg::result_t      out_res
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    mbrup_pkg::result_t entry_reg [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
        pop          = (count_reg != '0) && out_ready;
        out_valid    = (count_reg != '0);
        out_res      = entry_reg[rd_ptr_reg];
        space_ok     = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
        count_next   = count_reg - CNT_W'(pop) + CNT_W'(push.valid0) + CNT_W'(push.valid1);
        rd_ptr_next  = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        if (push.valid1) begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end else if (push.valid0) begin
            wr_ptr_next = wr_ptr_plus1;
        end else begin
            wr_ptr_next = wr_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1) begin
            entry_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MBRUP_ASSERT_NOW(a_push_has_room, aclk, aresetn, push.valid0, count_reg <= CNT_W'(QUEUE_DEPTH - 2), "push into full queue")
    `MBRUP_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `MBRUP_ASSERT_NOW(a_pair_order, aclk, aresetn, push.valid1, push.valid0, "second result without first")

endmodule

`default_nettype wire

@@ rtl/core/mono_bitmap_row_unpad_pack_core.sv @@
// Top level of the mono bitmap row unpack/pack core: config registers and datapath.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata = src_byte
//  m_*       out  m_tvalid/m_tready   m_tdata = packed_byte, m_tlast = last_byte
//  apb       in   psel/penable        box_width @0x0, box_height @0x4
//
// One source beat per cycle while s_tready is high; results are written into the result queue before they reach m_*.
// A glyph end can yield two result beats from one source beat; the result queue absorbs it.
// s_tready drops when the queue has fewer than two free entries.
// aresetn is synchronous, active low; box_width resets to 8, box_height to 0.
`default_nettype none

module mono_bitmap_row_unpad_pack_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] src_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] packed_byte
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    mbrup_pkg::cfg_t    cfg_reg, cfg_next;
    mbrup_pkg::push_t   push;
    mbrup_pkg::result_t out_res;
    logic               space_ok;
    logic               in_beat;
    logic               wr_en;
    logic               reg_sel;

    assign pready   = 1'b1;
    assign reg_sel  = paddr[2];
    assign wr_en    = psel && penable && pwrite && pready;
    assign s_tready = space_ok;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tdata  = out_res.packed_byte;
    assign m_tlast  = out_res.last_byte;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            if (reg_sel == 1'(mbrup_pkg::REG_BOX_HEIGHT)) begin
                cfg_next.box_height = pwdata[7:0];
            end else begin
                cfg_next.box_width = pwdata[7:0];
            end
        end
        if (reg_sel == 1'(mbrup_pkg::REG_BOX_HEIGHT)) begin
            prdata = {24'd0, cfg_reg.box_height};
        end else begin
            prdata = {24'd0, cfg_reg.box_width};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_width  <= mbrup_pkg::BOX_WIDTH_RESET;
            cfg_reg.box_height <= mbrup_pkg::BOX_HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mbrup_bit_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (in_beat),
        .src_byte (s_tdata),
        .cfg      (cfg_reg),
        .push     (push)
    );

    mbrup_out_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_mono_bitmap_row_unpad_pack_core.sv @@
// Testbench for mono_bitmap_row_unpad_pack_core: predicts packed glyph bytes and checks them.
`timescale 1ns / 100ps

module tb_mono_bitmap_row_unpad_pack_core;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_BYTES = 750;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] src_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] packed_byte
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    mono_bitmap_row_unpad_pack_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // glyph packer prediction state
    mbrup_pkg::cfg_t    box_cfg;
    logic [7:0]         pr_accum;
    int                 pr_fill;
    logic [4:0]         pr_col;
    logic [7:0]         pr_row;
    mbrup_pkg::result_t expected_packed[$];

    int          fail_count = 0;
    int          taken_bytes = 0;
    int unsigned cycle_count = 0;
    int          rx_hold = 0;
    bit          no_stall = 1'b0;

    function automatic void add_expected(input mbrup_pkg::result_t r);
        expected_packed.insert(expected_packed.size(), r);
    endfunction

    function automatic void pack_src_byte(input logic [7:0] src);
        int                 w;
        int                 row_len;
        int                 nbits;
        int                 n_new;
        bit                 end_row;
        mbrup_pkg::result_t r;
        if (box_cfg.box_height == 8'd0) begin
            return;
        end
        taken_bytes++;
        w = (box_cfg.box_width == 8'd0) ? 1 : int'(box_cfg.box_width);
        row_len = (w + 7) >> 3;
        end_row = (int'(pr_col) >= row_len - 1);
        nbits = end_row ? (((w - 1) & 7) + 1) : 8;
        n_new = 0;
        for (int i = 0; i < nbits; i++) begin
            pr_accum = {pr_accum[6:0], src[7 - i]};
            pr_fill++;
            if (pr_fill == 8) begin
                r.packed_byte = pr_accum;
                r.last_byte = 1'b0;
                add_expected(r);
                n_new++;
                pr_accum = 8'h00;
                pr_fill = 0;
            end
        end
        if (end_row) begin
            pr_col = 5'd0;
            if (int'(pr_row) >= int'(box_cfg.box_height) - 1) begin
                pr_row = 8'd0;
                if (pr_fill != 0) begin
                    r.packed_byte = pr_accum << (8 - pr_fill);
                    r.last_byte = 1'b1;
                    add_expected(r);
                end else if (n_new > 0) begin
                    r = expected_packed.pop_back();
                    r.last_byte = 1'b1;
                    add_expected(r);
                end
                pr_accum = 8'h00;
                pr_fill = 0;
            end else begin
                pr_row = pr_row + 8'd1;
            end
        end else begin
            pr_col = pr_col + 5'd1;
        end
    endfunction

    // result side: random stall after each beat, checked against the oldest prediction
    always @(posedge aclk) begin
        mbrup_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_packed.size() == 0) begin
                    $display("%0t: unexpected beat, got %02h last %0d", $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_packed.pop_front();
                    if (m_tdata !== want.packed_byte) begin
                        $display("%0t: packed_byte mismatch, expected %02h, actual %02h",
                                 $time, want.packed_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last_byte) begin
                        $display("%0t: last_byte mismatch, expected %0d, actual %0d",
                                 $time, want.last_byte, m_tlast);
                        fail_count++;
                    end
                end
                rx_hold = no_stall ? 0 : $urandom_range(0, 13);
            end
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, expected_packed.size());
            $display("** mono_bitmap_row_unpad_pack_core: FAILED **");
            $finish;
        end
    end

    task automatic send_src(input logic [7:0] b);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pack_src_byte(b);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_packed.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input int unsigned idx, input logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        if (idx == mbrup_pkg::REG_BOX_WIDTH) begin
            box_cfg.box_width = val;
        end else if (idx == mbrup_pkg::REG_BOX_HEIGHT) begin
            box_cfg.box_height = val;
        end
    endtask

    task automatic set_box(input logic [7:0] w, input logic [7:0] h);
        wait_drain();
        apb_write(mbrup_pkg::REG_BOX_WIDTH, w);
        apb_write(mbrup_pkg::REG_BOX_HEIGHT, h);
    endtask

    function automatic logic [7:0] pick_src();
        case ($urandom_range(0, 7))
            0: pick_src = 8'h00;
            1: pick_src = 8'hFF;
            default: pick_src = 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int glyph_bytes(input logic [7:0] w, input logic [7:0] h);
        int weff;
        weff = (w == 8'd0) ? 1 : int'(w);
        glyph_bytes = ((weff + 7) >> 3) * int'(h);
    endfunction

    // reset width of 8 with height 0 ignores input, then height 1 passes one byte through
    task automatic test_reset_config();
        send_src(8'hFF);
        send_src(8'h00);
        wait_drain();
        apb_write(mbrup_pkg::REG_BOX_HEIGHT, 8'd1);
        send_src(8'hA5);
    endtask

    task automatic test_narrow_widths();
        set_box(8'd1, 8'd2);
        send_src(8'h80);
        send_src(8'h7F);
        // width zero acts as one pixel
        set_box(8'd0, 8'd3);
        send_src(8'hFF);
        send_src(8'h01);
        send_src(8'h80);
    endtask

    task automatic test_exact_fill();
        set_box(8'd12, 8'd2);
        send_src(8'hFF);
        send_src(8'hF0);
        send_src(8'h00);
        send_src(8'h0F);
        set_box(8'd8, 8'd2);
        send_src(8'h00);
        send_src(8'hFF);
    endtask

    // one beat yields a full byte and the flush byte
    task automatic test_two_results();
        set_box(8'd7, 8'd2);
        send_src(8'hFE);
        send_src(8'h01);
    endtask

    task automatic test_width_change_mid_row();
        set_box(8'd20, 8'd1);
        send_src(8'h11);
        send_src(8'h22);
        wait_drain();
        apb_write(mbrup_pkg::REG_BOX_WIDTH, 8'd12);
        send_src(8'h5F);
    endtask

    task automatic test_height_change_mid_glyph();
        set_box(8'd4, 8'd4);
        send_src(8'h90);
        send_src(8'h60);
        wait_drain();
        apb_write(mbrup_pkg::REG_BOX_HEIGHT, 8'd2);
        send_src(8'hF0);
    endtask

    task automatic test_random_glyphs();
        int          start;
        int          kind;
        int          n;
        int          tall_count;
        logic [7:0]  w;
        logic [7:0]  h;
        start = taken_bytes;
        tall_count = 0;
        // widest row and tallest glyph once each up front
        set_box(8'd255, 8'd1);
        repeat (glyph_bytes(8'd255, 8'd1)) send_src(pick_src());
        set_box(8'd1, 8'd255);
        repeat (255) send_src(pick_src());
        while (taken_bytes - start < RANDOM_BYTES) begin
            no_stall = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                set_box(8'($urandom_range(0, 255)), 8'd0);
                repeat ($urandom_range(1, 4)) send_src(pick_src());
            end else if (kind == 1) begin
                h = 8'($urandom_range(1, 2));
                set_box(8'd255, h);
                repeat (glyph_bytes(8'd255, h)) send_src(pick_src());
            end else if (kind == 2 && tall_count < 1) begin
                tall_count++;
                set_box(8'd1, 8'd255);
                repeat (255) send_src(pick_src());
            end else if (kind <= 5) begin
                // broken glyph: reconfigure part way, then run until it closes
                w = 8'($urandom_range(1, 24));
                h = 8'($urandom_range(2, 6));
                set_box(w, h);
                n = $urandom_range(1, glyph_bytes(w, h) - 1);
                repeat (n) send_src(pick_src());
                wait_drain();
                if ($urandom_range(0, 1)) begin
                    apb_write(mbrup_pkg::REG_BOX_WIDTH, 8'($urandom_range(0, 24)));
                end else begin
                    apb_write(mbrup_pkg::REG_BOX_HEIGHT, 8'($urandom_range(1, 6)));
                end
                while (!(pr_row == 8'd0 && pr_col == 5'd0)) send_src(pick_src());
            end else begin
                if (box_cfg.box_height == 8'd0 || $urandom_range(0, 1)) begin
                    if ($urandom_range(0, 7) == 0) begin
                        w = 8'd0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        w = 8'($urandom_range(25, 64));
                    end else begin
                        w = 8'($urandom_range(1, 24));
                    end
                    set_box(w, 8'($urandom_range(1, 6)));
                end else if ($urandom_range(0, 5) == 0) begin
                    wait_drain();
                end
                repeat (glyph_bytes(box_cfg.box_width, box_cfg.box_height))
                    send_src(pick_src());
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        box_cfg.box_width = mbrup_pkg::BOX_WIDTH_RESET;
        box_cfg.box_height = mbrup_pkg::BOX_HEIGHT_RESET;
        pr_accum = 8'h00;
        pr_fill = 0;
        pr_col = 5'd0;
        pr_row = 8'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_narrow_widths();
        test_exact_fill();
        test_two_results();
        test_width_change_mid_row();
        test_height_change_mid_glyph();
        test_random_glyphs();

        wait_drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** mono_bitmap_row_unpad_pack_core: PASSED **");
        end else begin
            $display("** mono_bitmap_row_unpad_pack_core: FAILED **");
        end
        $finish;
    end

endmodule
